/* rtl/orb_pkg.sv */
// -----------------------------------------------------------------------------
// orb_pkg
// Shared field widths, command codes and the read request bundle of the
// overwriting ring buffer.
// -----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

	localparam int KIND_W  = 2;   // command kind field
	localparam int WORD_W  = 64;  // command word field
	localparam int COUNT_W = 7;   // remove count field
	localparam int ENTRY_W = 64;  // response entry field
	localparam int CFG_W   = 7;   // capacity register

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LIST   = 2'd2
	} kind_t;

	// read issued by the sequencer toward the output queue
	typedef struct packed {
		logic issue;
		logic last;
	} rd_req_t;

endpackage

`default_nettype wire

/* rtl/orb_cmd_if.sv */
// -----------------------------------------------------------------------------
// orb_cmd_if
// Command channel: kind, word and remove count with valid/ready.
// -----------------------------------------------------------------------------
`default_nettype none

interface orb_cmd_if
	import orb_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [WORD_W-1:0]  word;
	logic [COUNT_W-1:0] remove_count;

	modport source (output valid, output kind, output word, output remove_count, input ready);
	modport sink   (input valid, input kind, input word, input remove_count, output ready);
endinterface

`default_nettype wire

/* rtl/orb_rsp_if.sv */
// -----------------------------------------------------------------------------
// orb_rsp_if
// Response channel: listed entry and last flag with valid/ready.
// -----------------------------------------------------------------------------
`default_nettype none

interface orb_rsp_if
	import orb_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] entry;
	logic               last;

	modport source (output valid, output entry, output last, input ready);
	modport sink   (input valid, input entry, input last, output ready);
endinterface

`default_nettype wire

/* rtl/orb_cfg_if.sv */
// -----------------------------------------------------------------------------
// orb_cfg_if
// Configuration write channel carrying the capacity register value.
// -----------------------------------------------------------------------------
`default_nettype none

interface orb_cfg_if
	import orb_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/orb_mem.sv */
// -----------------------------------------------------------------------------
// orb_mem
// Ring storage: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module orb_mem #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 64
) (
	input  wire                         clk,
	input  wire                         we,
	input  wire [$clog2(DEPTH)-1:0]     waddr,
	input  wire [WORD_BITS-1:0]         wdata,
	input  wire                         re,
	input  wire [$clog2(DEPTH)-1:0]     raddr,
	output logic [WORD_BITS-1:0]        rdata_q
);

	logic [WORD_BITS-1:0] ram [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			ram[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= ram[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/orb_outq.sv */
// -----------------------------------------------------------------------------
// orb_outq
// Two-entry response queue behind the memory read port; grants read credits
// so that a stalled response never loses read data.
// -----------------------------------------------------------------------------
`default_nettype none

module orb_outq
	import orb_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rd_req_t              rd,
	input  wire [WORD_BITS-1:0]  rdata,
	output logic                 can_issue,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output logic [ENTRY_W-1:0]   rsp_entry,
	output logic                 rsp_last
);

	logic                 inflight_s1;
	logic                 last_s1;
	logic [1:0]           occ_q;
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [WORD_BITS:0]   slot_q [2];
	logic                 push;
	logic                 pop;
	logic [2:0]           pending;

	assign push = inflight_s1;
	assign pop  = rsp_valid && rsp_ready;

	// entries held or on the way, after this cycle's pop
	assign pending   = 3'({1'b0, occ_q}) + 3'(inflight_s1) - 3'(pop);
	assign can_issue = (pending <= 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_s1 <= 1'b0;
			occ_q       <= 2'd0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
		end else begin
			inflight_s1 <= rd.issue;
			occ_q       <= occ_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= rd.last;
		if (push) begin
			slot_q[wr_ptr_q] <= {last_s1, rdata};
		end
	end

	assign rsp_valid = (occ_q != 2'd0);
	assign rsp_entry = ENTRY_W'(slot_q[rd_ptr_q][WORD_BITS-1:0]);
	assign rsp_last  = slot_q[rd_ptr_q][WORD_BITS];

endmodule

`default_nettype wire

/* rtl/orb_ctrl.sv */
// -----------------------------------------------------------------------------
// orb_ctrl
// Head pointer, fill count and capacity; executes append and remove and
// sequences the list reads.
// -----------------------------------------------------------------------------
`default_nettype none

module orb_ctrl
	import orb_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 64
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cmd_valid,
	output logic                        cmd_ready,
	input  wire [KIND_W-1:0]            cmd_kind,
	input  wire [WORD_W-1:0]            cmd_word,
	input  wire [COUNT_W-1:0]           cmd_count,
	input  wire                         cfg_valid,
	input  wire [CFG_W-1:0]             cfg_data,
	input  wire                         can_issue,
	output logic                        mem_we,
	output logic [$clog2(DEPTH)-1:0]    mem_waddr,
	output logic [WORD_BITS-1:0]        mem_wdata,
	output logic [$clog2(DEPTH)-1:0]    mem_raddr,
	output rd_req_t                     rd
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LIST = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] rem_q;
	logic             accept;
	logic             full;
	logic [CNT_W-1:0] cap_new;
	logic [IDX_W-1:0] tail_pos;

	// a < cap and b <= cap: one conditional subtract wraps
	function automatic logic [IDX_W-1:0] ring_add(input logic [SUM_W-1:0] a,
	                                              input logic [SUM_W-1:0] b,
	                                              input logic [CNT_W-1:0] cap);
		logic [SUM_W-1:0] s;
		s = a + b;
		if (s >= SUM_W'(cap)) begin
			s = s - SUM_W'(cap);
		end
		return IDX_W'(s);
	endfunction

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign full      = (fill_q == cap_q);
	assign tail_pos  = ring_add(SUM_W'(head_q), SUM_W'(fill_q), cap_q);

	always_comb begin
		if (cfg_data == '0) begin
			cap_new = CNT_W'(1);
		end else if (cfg_data > CFG_W'(DEPTH)) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = CNT_W'(cfg_data);
		end
	end

	// write port: appends only
	always_comb begin
		mem_we    = accept && (kind_t'(cmd_kind) == KIND_APPEND);
		mem_waddr = full ? head_q : (tail_pos & IDX_MASK);
		mem_wdata = cmd_word[WORD_BITS-1:0];
	end

	assign rd.issue  = (state_q == ST_LIST) && can_issue;
	assign rd.last   = (rem_q == CNT_W'(1));
	assign mem_raddr = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CNT_W'(DEPTH);
			head_q  <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			rem_q   <= '0;
		end else if (cfg_valid) begin
			cap_q  <= cap_new;
			head_q <= '0;
			fill_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind_t'(cmd_kind))
							KIND_APPEND: begin
								if (full) begin
									head_q <= ring_add(SUM_W'(head_q), SUM_W'(1), cap_q);
								end else begin
									fill_q <= fill_q + CNT_W'(1);
								end
							end
							KIND_REMOVE: begin
								if ({1'b0, cmd_count} >= (COUNT_W + 1)'(fill_q)) begin
									head_q <= '0;
									fill_q <= '0;
								end else begin
									head_q <= ring_add(SUM_W'(head_q), SUM_W'(cmd_count), cap_q);
									fill_q <= fill_q - CNT_W'(cmd_count);
								end
							end
							KIND_LIST: begin
								if (fill_q != '0) begin
									state_q <= ST_LIST;
									pos_q   <= head_q;
									rem_q   <= fill_q;
								end
							end
							default: ;
						endcase
					end
				end
				ST_LIST: begin
					if (rd.issue) begin
						pos_q <= ring_add(SUM_W'(pos_q), SUM_W'(1), cap_q);
						rem_q <= rem_q - CNT_W'(1);
						if (rd.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/overwriting_ring_buffer.sv */
// -----------------------------------------------------------------------------
// overwriting_ring_buffer
// Circular buffer that keeps the newest words and overwrites the oldest once
// the configured capacity is reached; lists its contents on request.
// -----------------------------------------------------------------------------
// Timing: append and remove take effect in the cycle of the transaction; a list
//   entry passes the ST_LIST read, the memory read register and a queue slot.
// Throughput: append/remove one per cycle while no list is in progress; a list
//   holds off the command channel until its last read issues; one memory read
//   per cycle, limited only by the single read port and response backpressure.
// Reset: asynchronous, active low; buffer empty, head 0, capacity DEPTH.
//   Ring storage is not cleared; only written entries are ever read.
`default_nettype none

module overwriting_ring_buffer
	import orb_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 64
) (
	input  wire      clk,
	input  wire      arst_n,
	orb_cmd_if.sink  cmd,
	orb_rsp_if.source rsp,
	orb_cfg_if.sink  cfg
);

	localparam int IDX_W = $clog2(DEPTH);

	// memory ports
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]     mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	// sequencer to response queue
	rd_req_t rd;
	logic    can_issue;

	// capacity writes must arrive only while idle (the block does not enforce it); they are always taken
	assign cfg.ready = 1'b1;

	// Pointer/count logic. Appends write the tail (or the head when full);
	// a list walks the ring from head, one read per transaction credit.
	orb_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.cmd_kind  (cmd.kind),
		.cmd_word  (cmd.word),
		.cmd_count (cmd.remove_count),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.can_issue (can_issue),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.rd        (rd)
	);

	// Storage. Reads of a list and later appends never touch the same
	// entry in the same cycle before the read is taken.
	orb_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (rd.issue),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	// Two-slot queue decouples the read pipe from response backpressure.
	orb_outq #(
		.WORD_BITS (WORD_BITS)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.rdata     (mem_rdata),
		.can_issue (can_issue),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_entry (rsp.entry),
		.rsp_last  (rsp.last)
	);

endmodule

`default_nettype wire

/* rtl/orb_checker.sv */
// -----------------------------------------------------------------------------
// orb_checker
// Port-level checks of the ring buffer, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module orb_checker
	import orb_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input wire               clk,
	input wire               arst_n,
	input wire               cmd_ready,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input wire [ENTRY_W-1:0] rsp_entry,
	input wire               rsp_last
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry) && $stable(rsp_last))
		else $error("response changed while stalled");

	// bits above the stored word width are always zero
	a_rsp_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_entry >> WORD_BITS) == '0))
		else $error("entry carries bits above the word width");

	// while a list is being read out, entries keep arriving
	a_list_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> ##2 rsp_valid)
		else $error("list in progress but no entry presented");

endmodule

bind overwriting_ring_buffer orb_checker #(
	.WORD_BITS (WORD_BITS)
) u_orb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_entry (rsp.entry),
	.rsp_last  (rsp.last)
);

`default_nettype wire
